// ===== rtl/core/lmdb_pkg.sv =====
`timescale 1ns / 1ps

package lmdb_pkg;

    // Bank geometry
    localparam int NUM_CHANNELS_DEF = 16;
    localparam int CHAN_W           = 6;
    localparam int LEVEL_IN_W       = 18;
    localparam int LEVEL_W          = 16;

    // Configuration port
    localparam int CFG_IDX_W = 4;
    localparam int CFG_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THRESHOLD = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] DECAY_STEP_RST       = 16'd1311;
    localparam logic [CFG_W-1:0] CHANGE_THRESHOLD_RST = 16'd66;

    // Input command codes
    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_SEND
    } lmdb_state_t;

    // Controller to datapath
    typedef struct packed {
        logic              write_target; // store a set beat's level
        logic              tick_start;   // clear the repaint accumulator
        logic              rd_en;        // read both stores at addr
        logic              calc;         // update channel at addr, load result
        logic              is_last;      // channel at addr is the highest one
        logic [CHAN_W-1:0] addr;
    } lmdb_cmd_t;

    // Clamp a signed 18-bit level to 0..65535
    function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_IN_W-1:0] lvl);
        logic [LEVEL_W-1:0] res;
        if (lvl[LEVEL_IN_W-1]) begin
            res = '0;
        end else if (lvl[LEVEL_IN_W-2]) begin
            res = LEVEL_MAX;
        end else begin
            res = lvl[LEVEL_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/lmdb_ctrl.sv =====
`timescale 1ns / 1ps

module lmdb_ctrl #(
    parameter int NUM_CHANNELS = lmdb_pkg::NUM_CHANNELS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_command,
    input  logic [lmdb_pkg::CHAN_W-1:0] s_channel,
    output logic                  m_valid,
    input  logic                  m_ready,
    output lmdb_pkg::lmdb_cmd_t   cmd
);

    localparam int BANK = NUM_CHANNELS + 2;
    localparam logic [lmdb_pkg::CHAN_W-1:0] LAST_IDX = lmdb_pkg::CHAN_W'(BANK - 1);

    lmdb_pkg::lmdb_state_t state_reg, state_next;
    logic [lmdb_pkg::CHAN_W-1:0] idx_reg, idx_next;

    // State and channel counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lmdb_pkg::ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        s_ready          = 1'b0;
        m_valid          = 1'b0;
        cmd              = '0;
        cmd.addr         = idx_reg;
        cmd.is_last      = (idx_reg == LAST_IDX);
        unique case (state_reg)
            lmdb_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.addr = s_channel;
                if (s_valid) begin
                    if (s_command == lmdb_pkg::CMD_TICK) begin
                        // Start the walk at channel 0
                        cmd.tick_start = 1'b1;
                        cmd.rd_en      = 1'b1;
                        cmd.addr       = '0;
                        idx_next       = '0;
                        state_next     = lmdb_pkg::ST_CALC;
                    end else begin
                        cmd.write_target = 1'b1;
                    end
                end
            end
            lmdb_pkg::ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = lmdb_pkg::ST_SEND;
            end
            lmdb_pkg::ST_SEND: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (idx_reg == LAST_IDX) begin
                        state_next = lmdb_pkg::ST_IDLE;
                    end else begin
                        // Prefetch the next channel while this beat leaves
                        idx_next   = idx_reg + 1'b1;
                        cmd.rd_en  = 1'b1;
                        cmd.addr   = idx_reg + 1'b1;
                        state_next = lmdb_pkg::ST_CALC;
                    end
                end
            end
            default: begin
                state_next = lmdb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/lmdb_datapath.sv =====
`timescale 1ns / 1ps

module lmdb_datapath #(
    parameter int NUM_CHANNELS = lmdb_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lmdb_pkg::lmdb_cmd_t                 cmd,
    input  logic [lmdb_pkg::LEVEL_IN_W-1:0]     s_level,
    input  logic                                cfg_valid,
    input  logic [lmdb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lmdb_pkg::CFG_W-1:0]          cfg_data,
    output logic [lmdb_pkg::CHAN_W-1:0]         m_out_channel,
    output logic [lmdb_pkg::LEVEL_W-1:0]        m_display_level,
    output logic                                m_channel_changed,
    output logic                                m_last,
    output logic                                m_repaint
);

    localparam int BANK   = NUM_CHANNELS + 2;
    localparam int ADDR_W = $clog2(BANK);
    localparam int LW     = lmdb_pkg::LEVEL_W;

    logic [LW-1:0] decay_step_reg, change_thr_reg;

    logic [LW-1:0] tgt_mem  [BANK];
    logic [LW-1:0] disp_mem [BANK];
    logic [BANK-1:0] tgt_vld_reg, disp_vld_reg;

    logic [LW-1:0] tgt_rd_reg, disp_rd_reg;
    logic          tgt_rd_vld_reg, disp_rd_vld_reg;

    logic          any_reg;

    logic [ADDR_W-1:0] addr;
    logic              set_in_bank;
    logic              tgt_we, disp_we;
    logic [LW-1:0]     tgt, cur, cand, delta, disp_new;
    logic              chg;

    logic [lmdb_pkg::CHAN_W-1:0] out_channel_reg;
    logic [LW-1:0]               display_level_reg;
    logic                        changed_reg, last_reg, repaint_reg;

    assign addr        = cmd.addr[ADDR_W-1:0];
    assign set_in_bank = ({1'b0, cmd.addr} < (lmdb_pkg::CHAN_W + 1)'(BANK));
    assign tgt_we      = cmd.write_target && set_in_bank;
    assign disp_we     = cmd.calc && chg;

    // Configuration registers; writes to unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_step_reg <= lmdb_pkg::DECAY_STEP_RST;
            change_thr_reg <= lmdb_pkg::CHANGE_THRESHOLD_RST;
        end else if (cfg_valid) begin
            if (cfg_index == lmdb_pkg::REG_DECAY_STEP) begin
                decay_step_reg <= cfg_data;
            end
            if (cfg_index == lmdb_pkg::REG_CHANGE_THRESHOLD) begin
                change_thr_reg <= cfg_data;
            end
        end
    end

    // Per-entry valid bits: an unwritten entry reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tgt_vld_reg  <= '0;
            disp_vld_reg <= '0;
        end else begin
            if (tgt_we) begin
                tgt_vld_reg[addr] <= 1'b1;
            end
            if (disp_we) begin
                disp_vld_reg[addr] <= 1'b1;
            end
        end
    end

    // Target and display stores with registered reads
    always_ff @(posedge aclk) begin
        if (tgt_we) begin
            tgt_mem[addr] <= lmdb_pkg::clamp_level(s_level);
        end
        if (disp_we) begin
            disp_mem[addr] <= disp_new;
        end
        if (cmd.rd_en) begin
            tgt_rd_reg      <= tgt_mem[addr];
            disp_rd_reg     <= disp_mem[addr];
            tgt_rd_vld_reg  <= tgt_vld_reg[addr];
            disp_rd_vld_reg <= disp_vld_reg[addr];
        end
    end

    // Attack / decay update of one channel
    always_comb begin
        tgt = tgt_rd_vld_reg  ? tgt_rd_reg  : '0;
        cur = disp_rd_vld_reg ? disp_rd_reg : '0;
        if (tgt > cur) begin
            cand  = tgt;
            delta = tgt - cur;
        end else begin
            cand  = ((cur - tgt) > decay_step_reg) ? (cur - decay_step_reg) : tgt;
            delta = cur - cand;
        end
        chg      = (delta > change_thr_reg);
        disp_new = chg ? cand : cur;
    end

    // Repaint accumulator over one tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            any_reg <= 1'b0;
        end else if (cmd.tick_start) begin
            any_reg <= 1'b0;
        end else if (cmd.calc) begin
            any_reg <= any_reg | chg;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            out_channel_reg   <= cmd.addr;
            display_level_reg <= disp_new;
            changed_reg       <= chg;
            last_reg          <= cmd.is_last;
            repaint_reg       <= cmd.is_last && (any_reg || chg);
        end
    end

    assign m_out_channel     = out_channel_reg;
    assign m_display_level   = display_level_reg;
    assign m_channel_changed = changed_reg;
    assign m_last            = last_reg;
    assign m_repaint         = repaint_reg;

endmodule

// ===== rtl/core/level_meter_decay_bank_core.sv =====
// Set beat: accepted while idle, gives no result; the block stays idle and takes the next beat the cycle after.
// Tick beat: walks NUM_CHANNELS+2 channels, each in an update state and then a send state
// that holds the result until m_ready takes it, reading the next channel as it leaves;
// after the last result is taken the block returns to idle for the next beat.
// Reset (aresetn low, synchronous) idles the controller, restores both config
// registers to their defaults and clears the per-channel valid bits, so all levels read zero.
`timescale 1ns / 1ps

module level_meter_decay_bank_core #(
    parameter int NUM_CHANNELS = lmdb_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic [lmdb_pkg::CHAN_W-1:0]         s_channel,
    input  logic [lmdb_pkg::LEVEL_IN_W-1:0]     s_level,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [lmdb_pkg::CHAN_W-1:0]         m_out_channel,
    output logic [lmdb_pkg::LEVEL_W-1:0]        m_display_level,
    output logic                                m_channel_changed,
    output logic                                m_last,
    output logic                                m_repaint,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lmdb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lmdb_pkg::CFG_W-1:0]          cfg_data
);

    lmdb_pkg::lmdb_cmd_t cmd;

    assign cfg_ready = 1'b1;

    lmdb_ctrl #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_channel (s_channel),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd)
    );

    lmdb_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .s_level           (s_level),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .m_out_channel     (m_out_channel),
        .m_display_level   (m_display_level),
        .m_channel_changed (m_channel_changed),
        .m_last            (m_last),
        .m_repaint         (m_repaint)
    );

endmodule

// ===== rtl/core/lmdb_checker.sv =====
`timescale 1ns / 1ps

module lmdb_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic s_command,
    input logic m_valid,
    input logic m_ready,
    input logic m_last,
    input logic m_repaint
);

    // No new beat is taken while a result is pending
    a_busy_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while a result is pending");

    // Last result of a tick returns the block to idle
    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> (s_ready && !m_valid))
        else $error("block not idle after last result");

    // Between two channel results the block passes through an update state
    a_gap_between: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> (!m_valid && !s_ready))
        else $error("missing update cycle between results");

    // A tick beat starts the walk
    a_tick_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_command == lmdb_pkg::CMD_TICK) |=> (!s_ready && !m_valid))
        else $error("tick did not start a walk");

    // Repaint only on the last result
    a_repaint_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> !m_repaint)
        else $error("repaint flag on a non-final result");

endmodule

bind level_meter_decay_bank_core lmdb_checker u_lmdb_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_command (s_command),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_last    (m_last),
    .m_repaint (m_repaint)
);
